// ===== src/bpf_pkg.sv =====
package bpf_pkg;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned SUM_W  = 10;
    localparam int unsigned PROD_W = 16;
    localparam int unsigned NUM_W  = 17;
    localparam int unsigned DEN_W  = 11;
    localparam int unsigned QUO_W  = 8;
    localparam int unsigned NCH    = 3;

    typedef struct packed {
        logic [PIX_W-1:0]               pan;
        logic                           zero;
        logic [DEN_W-1:0]               den;
        logic [NCH-1:0][NUM_W-1:0]      rem;
        logic [NCH-1:0][QUO_W-1:0]      quo;
    } t_div_item;

endpackage

// ===== src/bpf_front.sv =====
module bpf_front
    import bpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [PIX_W-1:0]  i_red,
    input  logic [PIX_W-1:0]  i_green,
    input  logic [PIX_W-1:0]  i_blue,
    input  logic [PIX_W-1:0]  i_pan,
    output logic              o_valid,
    input  logic              i_ready,
    output t_div_item         o_item
);

    logic                        r_a_valid;
    logic [SUM_W-1:0]            r_a_sum;
    logic [NCH-1:0][PROD_W-1:0]  r_a_prod;
    logic [PIX_W-1:0]            r_a_pan;
    logic                        r_b_valid;
    t_div_item                   r_b_item;
    t_div_item                   n_b_item;
    logic                        a_ready;

    assign a_ready = !r_b_valid || i_ready;
    assign o_ready = !r_a_valid || a_ready;

    // stage a: colour sum and colour times pan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_a_sum     <= SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue);
            r_a_prod[0] <= PROD_W'(i_red) * PROD_W'(i_pan);
            r_a_prod[1] <= PROD_W'(i_green) * PROD_W'(i_pan);
            r_a_prod[2] <= PROD_W'(i_blue) * PROD_W'(i_pan);
            r_a_pan     <= i_pan;
        end
    end

    // stage b: rounding numerator and doubled denominator
    always_comb begin
        n_b_item.pan  = r_a_pan;
        n_b_item.zero = (r_a_sum == '0);
        n_b_item.den  = {r_a_sum, 1'b0};
        for (int i = 0; i < NCH; i++) begin
            n_b_item.rem[i] = {r_a_prod[i], 1'b0} + NUM_W'(r_a_sum);
            n_b_item.quo[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (a_ready && r_a_valid) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

// ===== src/bpf_div_stage.sv =====
module bpf_div_stage
    import bpf_pkg::*;
#(
    parameter int unsigned BIT = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_div_item  i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_div_item  o_item
);

    logic              r_valid;
    t_div_item         r_item;
    t_div_item         n_item;
    logic [NUM_W:0]    dsh;
    logic [NCH-1:0]    ge;

    assign dsh     = (NUM_W+1)'(i_item.den) << BIT;
    assign o_ready = !r_valid || i_ready;

    // one restoring quotient bit per channel
    always_comb begin
        n_item = i_item;
        for (int i = 0; i < NCH; i++) begin
            ge[i] = ({1'b0, i_item.rem[i]} >= dsh);
            if (ge[i]) begin
                n_item.rem[i] = i_item.rem[i] - dsh[NUM_W-1:0];
            end
            n_item.quo[i][BIT] = ge[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/brovey_pan_fusion.sv =====
// pipeline: 2 front stages, 8 divider stages, 1 output register
// throughput: one pixel per cycle while i_ready is held high; each divider stage resolves one quotient bit
// stalls fill bubbles stage by stage, nothing is dropped or repeated
// reset: synchronous active-low i_rst_n clears all valid bits, pipeline empty
module brovey_pan_fusion
    import bpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [PIX_W-1:0]  i_red_in,
    input  logic [PIX_W-1:0]  i_green_in,
    input  logic [PIX_W-1:0]  i_blue_in,
    input  logic [PIX_W-1:0]  i_pan,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PIX_W-1:0]  o_pan_out,
    output logic [PIX_W-1:0]  o_red_out,
    output logic [PIX_W-1:0]  o_green_out,
    output logic [PIX_W-1:0]  o_blue_out,
    output logic              o_zero_sum
);

    t_div_item         items [QUO_W+1];
    logic              vld   [QUO_W+1];
    logic              rdy   [QUO_W+1];
    logic              r_valid;
    logic [PIX_W-1:0]  r_pan;
    logic [PIX_W-1:0]  r_red;
    logic [PIX_W-1:0]  r_green;
    logic [PIX_W-1:0]  r_blue;
    logic              r_zero;
    logic              out_ready;

    bpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .i_pan   (i_pan),
        .o_valid (vld[0]),
        .i_ready (rdy[0]),
        .o_item  (items[0])
    );

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        bpf_div_stage #(
            .BIT (QUO_W-1-k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .o_ready (rdy[k]),
            .i_item  (items[k]),
            .o_valid (vld[k+1]),
            .i_ready (rdy[k+1]),
            .o_item  (items[k+1])
        );
    end

    assign out_ready     = !r_valid || i_ready;
    assign rdy[QUO_W]    = out_ready;

    // quotient never exceeds pan, so 8 bits already hold the clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_ready) begin
            r_valid <= vld[QUO_W];
        end
        if (out_ready && vld[QUO_W]) begin
            r_pan   <= items[QUO_W].pan;
            r_zero  <= items[QUO_W].zero;
            r_red   <= items[QUO_W].zero ? '0 : items[QUO_W].quo[0];
            r_green <= items[QUO_W].zero ? '0 : items[QUO_W].quo[1];
            r_blue  <= items[QUO_W].zero ? '0 : items[QUO_W].quo[2];
        end
    end

    assign o_valid     = r_valid;
    assign o_pan_out   = r_pan;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_zero_sum  = r_zero;

    logic [SUM_W-1:0] out_sum;
    assign out_sum = SUM_W'(r_red) + SUM_W'(r_green) + SUM_W'(r_blue);

    a_share_le_pan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_red <= r_pan) && (r_green <= r_pan) && (r_blue <= r_pan))
        else $error("colour output exceeds pan");

    a_sum_near_pan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_zero) |->
            (out_sum <= SUM_W'(r_pan) + SUM_W'(1)) && (out_sum + SUM_W'(1) >= SUM_W'(r_pan)))
        else $error("rounded colours do not add up to pan");

    a_zero_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_zero) |-> (out_sum == '0))
        else $error("zero sum with nonzero colour");

    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld[QUO_W] && !items[QUO_W].zero) |->
            (items[QUO_W].rem[0] < NUM_W'(items[QUO_W].den)) &&
            (items[QUO_W].rem[1] < NUM_W'(items[QUO_W].den)) &&
            (items[QUO_W].rem[2] < NUM_W'(items[QUO_W].den)))
        else $error("divider remainder not reduced");

endmodule
